FILE: rtl/core/small_matrix_add_sub_multiply_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix add/subtract/multiply core.
// Each macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_ADD_SUB_MULTIPLY_CORE_DEFINES_SVH
`define SMALL_MATRIX_ADD_SUB_MULTIPLY_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMAS_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smas: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMAS_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smas: next-cycle check failed");

`endif

FILE: rtl/core/smas_pkg.sv
// ----------------------------------------------------------------------------
// smas_pkg
// Shared constants, codes, types and helpers of the matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package smas_pkg;

  // Storage geometry: each matrix is MAX_DIM x MAX_DIM words.
  localparam int MAX_DIM   = 8;
  localparam int DIM_BOUND = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int COORD_W   = 3;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(5);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  // Input operation codes.
  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4
  } opcode_t;

  // Operation of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT,
    ST_ERROR
  } state_t;

  // Control that travels with each operand pair into the arithmetic unit.
  typedef struct packed {
    logic    valid;
    logic    first;
    logic    tail;
    alu_op_t op;
  } mac_ctl_t;

  // Highest usable index for a configured count, with the count clamped to 1..DIM_BOUND.
  function automatic logic [COORD_W-1:0] dim_last(input logic [CFG_W-1:0] cnt);
    if (cnt == '0) begin
      return '0;
    end else if (cnt > CFG_W'(DIM_BOUND)) begin
      return COORD_W'(DIM_BOUND - 1);
    end else begin
      return COORD_W'(cnt - 1'b1);
    end
  endfunction

  // Word address of an element in a row-major store.
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM)) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/smas_mac.sv
// ----------------------------------------------------------------------------
// smas_mac
// Shared arithmetic unit: add, subtract or multiply one operand pair, then
// accumulate. A registered result stage sits between the two steps.
// ----------------------------------------------------------------------------
`default_nettype none

module smas_mac import smas_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mac_ctl_t          ctl,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DATA_W-1:0] b,
  output logic      [DATA_W-1:0] acc,
  output logic                   done
);

  logic              prod_valid;
  logic              prod_first;
  logic              prod_tail;
  logic [DATA_W-1:0] prod;

  // First stage control: which operand pairs are live.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.valid;
    end
  end

  // First stage payload: one add, subtract or low-half multiply.
  always_ff @(posedge clk) begin
    prod_first <= ctl.first;
    prod_tail  <= ctl.tail;
    unique case (ctl.op)
      ALU_ADD: prod <= a + b;
      ALU_SUB: prod <= a - b;
      ALU_MUL: prod <= a * b;
      default: prod <= '0;
    endcase
  end

  // Second stage: accumulate, restarting on the first term of an element.
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= prod_first ? prod : acc + prod;
    end
  end

  // Done pulses once the last term of an element has been accumulated.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_valid & prod_tail;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/small_matrix_add_sub_multiply_core.sv
// ----------------------------------------------------------------------------
// small_matrix_add_sub_multiply_core
// Holds two signed 32-bit matrices and emits their sum, difference or
// product in row-major order, one element per output transaction.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  config    cfg_we               cfg_index, cfg_data
//  input     in_valid / in_ready  opcode, row_index, col_index, element_value
//  output    out_valid/out_ready  out_row, out_col, out_value, status, last
//
//  A load is written to its store as it is accepted. Each element of an add
//  or subtract is one pass through the one multiply-accumulate unit; each
//  element of a multiply of size n takes n passes, plus the memory read,
//  product and accumulate stages, before the next element is issued.
//  Reset is synchronous and clears control state only; stored elements are
//  undefined until loaded. A stalled output holds its transaction and pauses
//  the sequencer before the next element; in_ready is high only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module small_matrix_add_sub_multiply_core import smas_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           opcode,
  input  wire logic [COORD_W-1:0]   row_index,
  input  wire logic [COORD_W-1:0]   col_index,
  input  wire logic signed [31:0]   element_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [COORD_W-1:0]        out_row,
  output logic [COORD_W-1:0]        out_col,
  output logic signed [31:0]        out_value,
  output logic                      status,
  output logic                      last
);

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  logic [CFG_W-1:0]   row_count;
  logic [CFG_W-1:0]   col_count;
  logic [COORD_W-1:0] row_last;
  logic [COORD_W-1:0] col_last;

  state_t             state, state_next;
  alu_op_t            op_reg, op_next;
  logic [COORD_W-1:0] i_cnt, i_next;
  logic [COORD_W-1:0] j_cnt, j_next;
  logic [COORD_W-1:0] p_cnt, p_next;

  logic               accept;
  logic               load_in_range;
  logic               wr_a;
  logic               wr_b;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  a_raddr;
  logic [ADDR_W-1:0]  b_raddr;
  logic [DATA_W-1:0]  rd_a;
  logic [DATA_W-1:0]  rd_b;
  mac_ctl_t           issue;
  mac_ctl_t           rd_ctl;
  logic [COORD_W-1:0] p_last;
  logic [DATA_W-1:0]  acc;
  logic               acc_done;
  logic               out_free;
  logic               emit_last;
  logic               out_load;
  logic               err_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CFG_DIM_RESET;
      col_count <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count <= cfg_data;
        CFG_COL_COUNT: col_count <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign row_last = dim_last(row_count);
  assign col_last = dim_last(col_count);

  assign in_ready      = (state == ST_IDLE);
  assign accept        = in_valid & in_ready;
  assign load_in_range = (row_index <= row_last) && (col_index <= col_last);
  assign wr_addr       = elem_addr(row_index, col_index);
  assign out_free      = !out_valid || out_ready;
  assign emit_last     = (i_cnt == row_last) && (j_cnt == col_last);
  assign p_last        = (op_reg == ALU_MUL) ? col_last : '0;

  // Read addresses: element-wise for add and subtract, row by column for
  // multiply.
  always_comb begin
    if (op_reg == ALU_MUL) begin
      a_raddr = elem_addr(i_cnt, p_cnt);
      b_raddr = elem_addr(p_cnt, j_cnt);
    end else begin
      a_raddr = elem_addr(i_cnt, j_cnt);
      b_raddr = elem_addr(i_cnt, j_cnt);
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next = state;
    op_next    = op_reg;
    i_next     = i_cnt;
    j_next     = j_cnt;
    p_next     = p_cnt;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    out_load   = 1'b0;
    err_load   = 1'b0;
    issue      = '{valid: 1'b0, first: 1'b0, tail: 1'b0, op: op_reg};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          i_next = '0;
          j_next = '0;
          p_next = '0;
          unique case (opcode)
            OP_LOAD_A: wr_a = load_in_range;
            OP_LOAD_B: wr_b = load_in_range;
            OP_ADD: begin
              op_next    = ALU_ADD;
              state_next = ST_ISSUE;
            end
            OP_SUB: begin
              op_next    = ALU_SUB;
              state_next = ST_ISSUE;
            end
            OP_MUL: begin
              op_next    = ALU_MUL;
              state_next = (row_last == col_last) ? ST_ISSUE : ST_ERROR;
            end
            default: ;
          endcase
        end
      end

      // Feed one operand pair per cycle into the shared unit.
      ST_ISSUE: begin
        issue.valid = 1'b1;
        issue.first = (p_cnt == '0);
        issue.tail  = (p_cnt == p_last);
        if (p_cnt == p_last) begin
          p_next     = '0;
          state_next = ST_DRAIN;
        end else begin
          p_next = p_cnt + 1'b1;
        end
      end

      // Wait for the last term to leave the accumulator.
      ST_DRAIN: begin
        if (acc_done) begin
          state_next = ST_EMIT;
        end
      end

      // Hand the element to the output register and step to the next one.
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ISSUE;
            if (j_cnt == col_last) begin
              j_next = '0;
              i_next = i_cnt + 1'b1;
            end else begin
              j_next = j_cnt + 1'b1;
            end
          end
        end
      end

      // Refused multiply: one error transaction.
      ST_ERROR: begin
        if (out_free) begin
          err_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op_reg <= ALU_ADD;
      i_cnt <= '0;
      j_cnt <= '0;
      p_cnt <= '0;
    end else begin
      state <= state_next;
      op_reg <= op_next;
      i_cnt <= i_next;
      j_cnt <= j_next;
      p_cnt <= p_next;
    end
  end

  // Matrix stores: one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= element_value;
    end
    rd_a <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= element_value;
    end
    rd_b <= mem_b[b_raddr];
  end

  // Control travels alongside the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '{valid: 1'b0, first: 1'b0, tail: 1'b0, op: ALU_ADD};
    end else begin
      rd_ctl <= issue;
    end
  end

  smas_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .a    (rd_a),
    .b    (rd_b),
    .acc  (acc),
    .done (acc_done)
  );

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load || err_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row   <= i_cnt;
      out_col   <= j_cnt;
      out_value <= acc;
      status    <= 1'b0;
      last      <= emit_last;
    end else if (err_load) begin
      out_row   <= '0;
      out_col   <= '0;
      out_value <= '0;
      status    <= 1'b1;
      last      <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/smas_checker.sv
// ----------------------------------------------------------------------------
// smas_checker
// Port-level checks on the matrix core, attached to it by bind.
// ----------------------------------------------------------------------------
`include "small_matrix_add_sub_multiply_core_defines.svh"
`default_nettype none

module smas_checker import smas_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [2:0]           opcode,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [COORD_W-1:0]   out_row,
  input wire logic [COORD_W-1:0]   out_col,
  input wire logic signed [31:0]   out_value,
  input wire logic                 status,
  input wire logic                 last
);

  logic op_take;
  logic err_zero;
  logic out_stall;

  // A compute operation is taken, an error element is all zero, the output stalls.
  assign op_take   = in_valid && in_ready &&
                     (opcode == OP_ADD || opcode == OP_SUB || opcode == OP_MUL);
  assign err_zero  = (out_value == 0) && (out_row == 0) && (out_col == 0);
  assign out_stall = out_valid && !out_ready;

  // A refused multiply is always a single, final transaction.
  `SMAS_CHECK_NOW(a_err_is_last, out_valid && status, last)

  // A refused multiply carries an all-zero element.
  `SMAS_CHECK_NOW(a_err_zero, out_valid && status, err_zero)

  // Once a compute operation is taken, the block is busy next cycle.
  `SMAS_CHECK_NEXT(a_busy_after_op, op_take, !in_ready)

  // A stalled output transaction holds its value.
  `SMAS_CHECK_NEXT(a_out_hold, out_stall, out_valid && $stable(out_value) && $stable(last))

endmodule

bind small_matrix_add_sub_multiply_core smas_checker u_smas_checker (.*);

`default_nettype wire

FILE: dv/small_matrix_add_sub_multiply_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix core result checker
// Watches the configuration port and both channels of the matrix core. It
// keeps its own copy of the two element stores and the size registers,
// works out the elements that every accepted operation must produce and
// compares each output transaction with the oldest of them.
// ----------------------------------------------------------------------------
module small_matrix_add_sub_multiply_core_checker import smas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [2:0]           opcode,
  input  logic [COORD_W-1:0]   row_index,
  input  logic [COORD_W-1:0]   col_index,
  input  logic [DATA_W-1:0]    element_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [COORD_W-1:0]   out_row,
  input  logic [COORD_W-1:0]   out_col,
  input  logic [DATA_W-1:0]    out_value,
  input  logic                 status,
  input  logic                 last,
  output int                   mismatch_count,
  output int                   results_waiting,
  output int                   results_checked
);

  // One emitted matrix element as it appears on the output channel.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  value;
    logic               status;
    logic               last;
  } elem_result_t;

  logic [DATA_W-1:0] a_store [DEPTH];
  logic [DATA_W-1:0] b_store [DEPTH];
  logic [CFG_W-1:0]  rows_reg = CFG_DIM_RESET;
  logic [CFG_W-1:0]  cols_reg = CFG_DIM_RESET;
  elem_result_t      expected_elems [$];
  int                fail_tally = 0;
  int                checked_tally = 0;

  // A register value of zero behaves as one, anything past the store as the bound.
  function automatic int usable_dim(input logic [CFG_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > CFG_W'(DIM_BOUND)) begin
      return DIM_BOUND;
    end
    return int'(raw);
  endfunction

  // Apply one accepted transaction to the stores and queue the elements it produces.
  task automatic apply_matrix_op(input logic [2:0] op, input logic [COORD_W-1:0] r,
                                 input logic [COORD_W-1:0] c,
                                 input logic [DATA_W-1:0] v);
    int nr;
    int nc;
    int i;
    int j;
    int p;
    logic [DATA_W-1:0] acc;
    elem_result_t elem;
    nr = usable_dim(rows_reg);
    nc = usable_dim(cols_reg);
    case (op)
      OP_LOAD_A, OP_LOAD_B: begin
        // Loads outside the configured size are dropped.
        if (int'(r) < nr && int'(c) < nc) begin
          if (op == OP_LOAD_A) begin
            a_store[int'(r) * MAX_DIM + int'(c)] = v;
          end else begin
            b_store[int'(r) * MAX_DIM + int'(c)] = v;
          end
        end
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        if (op == OP_MUL && nr != nc) begin
          // A non-square product is refused with a single error element.
          elem = '{row: '0, col: '0, value: '0, status: 1'b1, last: 1'b1};
          expected_elems.push_back(elem);
        end else begin
          for (i = 0; i < nr; i++) begin
            for (j = 0; j < nc; j++) begin
              if (op == OP_ADD) begin
                acc = a_store[i * MAX_DIM + j] + b_store[i * MAX_DIM + j];
              end else if (op == OP_SUB) begin
                acc = a_store[i * MAX_DIM + j] - b_store[i * MAX_DIM + j];
              end else begin
                acc = '0;
                for (p = 0; p < nc; p++) begin
                  acc = acc + a_store[i * MAX_DIM + p] * b_store[p * MAX_DIM + j];
                end
              end
              elem = '{row: COORD_W'(i), col: COORD_W'(j), value: acc, status: 1'b0,
                       last: (i == nr - 1 && j == nc - 1)};
              expected_elems.push_back(elem);
            end
          end
        end
      end
      default: begin
        // Unused opcodes are ignored by the core.
      end
    endcase
  endtask

  function automatic void report_mismatch(input string why, input elem_result_t exp_r,
                                          input elem_result_t got_r);
    fail_tally++;
    if (fail_tally <= 10) begin
      $display("[%0t] %s: expected row %0d col %0d value %0d status %0b last %0b,",
               $realtime, why, exp_r.row, exp_r.col, $signed(exp_r.value), exp_r.status,
               exp_r.last);
      $display("    got row %0d col %0d value %0d status %0b last %0b",
               got_r.row, got_r.col, $signed(got_r.value), got_r.status, got_r.last);
    end
  endfunction

  // Compare one output transaction with the oldest outstanding element.
  task automatic check_output();
    elem_result_t got_r;
    elem_result_t exp_r;
    got_r = '{row: out_row, col: out_col, value: out_value, status: status, last: last};
    checked_tally++;
    if (expected_elems.size() == 0) begin
      report_mismatch("result with nothing outstanding", '0, got_r);
    end else begin
      exp_r = expected_elems.pop_front();
      if (got_r !== exp_r) begin
        report_mismatch("result mismatch", exp_r, got_r);
      end
    end
  endtask

  // Everything is sampled at the rising edge, before the core updates.
  always @(posedge clk) begin
    if (rst) begin
      rows_reg = CFG_DIM_RESET;
      cols_reg = CFG_DIM_RESET;
      expected_elems.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_output();
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_COUNT) begin
          rows_reg = cfg_data;
        end else if (cfg_index == CFG_COL_COUNT) begin
          cols_reg = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        apply_matrix_op(opcode, row_index, col_index, element_value);
      end
    end
    mismatch_count  <= fail_tally;
    results_waiting <= expected_elems.size();
    results_checked <= checked_tally;
  end

endmodule

FILE: dv/small_matrix_add_sub_multiply_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix core testbench
// Loads elements of both matrices, runs add, subtract and multiply over a
// series of matrix sizes (register extremes included) and lets the checker
// compare every emitted element. Both channels idle in random bursts, except
// in a quiet stretch at the end of the run.
// ----------------------------------------------------------------------------
module small_matrix_add_sub_multiply_core_test;
  import smas_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEM_TARGET   = 230;
  localparam int TAIL_ITEMS    = 30;

  // Opcodes that the core does not define.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           opcode = OP_LOAD_A;
  logic [COORD_W-1:0]   row_index = '0;
  logic [COORD_W-1:0]   col_index = '0;
  logic signed [31:0]   element_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic signed [31:0]   out_value;
  logic                 status;
  logic                 last;

  int          mismatch_count;
  int          results_waiting;
  int          results_checked;
  logic        quiet_tail = 1'b0;
  int unsigned ready_burst = 0;
  int unsigned idle_cycles = 0;
  int          work_items = 0;
  int          ops_sent = 0;
  int          sizes_run = 0;
  int          eff_rows = 5;
  int          eff_cols = 5;
  bit          a_written [DEPTH];
  bit          b_written [DEPTH];

  always #1 clk = ~clk;

  small_matrix_add_sub_multiply_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .status        (status),
    .last          (last)
  );

  small_matrix_add_sub_multiply_core_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .row_index       (row_index),
    .col_index       (col_index),
    .element_value   (element_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .status          (status),
    .last            (last),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting),
    .results_checked (results_checked)
  );

  // Receiver: random bursts of stall and acceptance, always ready in the tail.
  always @(posedge clk) begin
    if (quiet_tail) begin
      out_ready <= 1'b1;
    end else if (ready_burst == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready   <= 1'b0;
        ready_burst <= $urandom_range(1, 8);
      end else begin
        out_ready   <= 1'b1;
        ready_burst <= $urandom_range(1, 40);
      end
    end else begin
      ready_burst <= ready_burst - 1;
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int usable_dim(input logic [CFG_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    return (raw > CFG_W'(DIM_BOUND)) ? DIM_BOUND : int'(raw);
  endfunction

  // Element values lean toward the wrap-around corners.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Present one input transaction and hold it until the core takes it.
  task automatic send_item(input logic [2:0] op, input logic [COORD_W-1:0] r,
                           input logic [COORD_W-1:0] c, input logic [31:0] v);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    opcode        <= op;
    row_index     <= r;
    col_index     <= c;
    element_value <= v;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    work_items++;
    if (op == OP_LOAD_A || op == OP_LOAD_B) begin
      if (int'(r) < eff_rows && int'(c) < eff_cols) begin
        if (op == OP_LOAD_A) begin
          a_written[int'(r) * MAX_DIM + int'(c)] = 1'b1;
        end else begin
          b_written[int'(r) * MAX_DIM + int'(c)] = 1'b1;
        end
      end
    end else if (op == OP_ADD || op == OP_SUB || op == OP_MUL) begin
      ops_sent++;
    end
  endtask

  // Hold off input until every outstanding element has come out, then settle.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers; only called while the core is idle.
  task automatic set_dims(input logic [CFG_W-1:0] raw_r, input logic [CFG_W-1:0] raw_c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= raw_r;
    @(posedge clk);
    cfg_index <= CFG_COL_COUNT;
    cfg_data  <= raw_c;
    @(posedge clk);
    cfg_we   <= 1'b0;
    eff_rows = usable_dim(raw_r);
    eff_cols = usable_dim(raw_c);
    sizes_run++;
  endtask

  // Load every element in the active size that has never been written.
  task automatic fill_region();
    int r;
    int c;
    for (r = 0; r < eff_rows; r++) begin
      for (c = 0; c < eff_cols; c++) begin
        if (!a_written[r * MAX_DIM + c]) begin
          send_item(OP_LOAD_A, COORD_W'(r), COORD_W'(c), pick_value());
        end
        if (!b_written[r * MAX_DIM + c]) begin
          send_item(OP_LOAD_B, COORD_W'(r), COORD_W'(c), pick_value());
        end
      end
    end
  endtask

  // Mostly in-size loads and operations, with some dropped loads and unused opcodes.
  task automatic random_item();
    int kind;
    int r;
    int c;
    logic [2:0] op;
    kind = $urandom_range(0, 19);
    if (kind < 10) begin
      op = ($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B;
      r  = $urandom_range(0, eff_rows - 1);
      c  = $urandom_range(0, eff_cols - 1);
      send_item(op, COORD_W'(r), COORD_W'(c), pick_value());
    end else if (kind < 16) begin
      case ($urandom_range(0, 2))
        0: op = OP_ADD;
        1: op = OP_SUB;
        default: op = OP_MUL;
      endcase
      send_item(op, COORD_W'($urandom), COORD_W'($urandom), $urandom);
    end else if (kind < 18 && (eff_rows < DIM_BOUND || eff_cols < DIM_BOUND)) begin
      if (eff_rows < DIM_BOUND && (eff_cols == DIM_BOUND || $urandom_range(0, 1) == 0)) begin
        r = $urandom_range(eff_rows, 7);
        c = $urandom_range(0, 7);
      end else begin
        r = $urandom_range(0, 7);
        c = $urandom_range(eff_cols, 7);
      end
      op = ($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B;
      send_item(op, COORD_W'(r), COORD_W'(c), pick_value());
    end else begin
      op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      send_item(op, COORD_W'($urandom), COORD_W'($urandom), $urandom);
    end
  endtask

  task automatic run_size(input logic [CFG_W-1:0] raw_r, input logic [CFG_W-1:0] raw_c,
                          input int count);
    drain_and_settle();
    set_dims(raw_r, raw_c);
    fill_region();
    repeat (count) random_item();
  endtask

  initial begin
    logic [CFG_W-1:0] raw_r;
    logic [CFG_W-1:0] raw_c;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset size is 5 x 5: the corner element lands, one past it is dropped.
    send_item(OP_LOAD_A, 3'd4, 3'd4, 32'h7fff_ffff);
    send_item(OP_LOAD_B, 3'd4, 3'd4, 32'h8000_0000);
    send_item(OP_LOAD_A, 3'd5, 3'd5, 32'h0000_1234);
    send_item(OP_UNUSED_LO, 3'd7, 3'd0, 32'hffff_ffff);
    send_item(OP_UNUSED_LO + 3'd1, 3'd0, 3'd7, 32'h0000_0000);
    send_item(OP_UNUSED_HI, 3'd7, 3'd7, 32'h5555_aaaa);

    // 2 x 2 with operands chosen so that sums, differences and products wrap.
    drain_and_settle();
    set_dims(4'd2, 4'd2);
    send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
    send_item(OP_LOAD_A, 3'd0, 3'd1, 32'h7fff_ffff);
    send_item(OP_LOAD_A, 3'd1, 3'd0, 32'hffff_ffff);
    send_item(OP_LOAD_A, 3'd1, 3'd1, 32'h0000_0000);
    send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
    send_item(OP_LOAD_B, 3'd0, 3'd1, 32'h0000_0001);
    send_item(OP_LOAD_B, 3'd1, 3'd0, 32'hffff_ffff);
    send_item(OP_LOAD_B, 3'd1, 3'd1, 32'h7fff_ffff);
    send_item(OP_ADD, 3'd0, 3'd0, 32'h0000_0000);
    send_item(OP_SUB, 3'd7, 3'd7, 32'hffff_ffff);
    send_item(OP_MUL, 3'd0, 3'd0, 32'h0000_0000);
    send_item(OP_LOAD_A, 3'd2, 3'd1, 32'h0000_0063);
    send_item(OP_LOAD_B, 3'd7, 3'd7, 32'h0000_0063);
    send_item(OP_LOAD_A, 3'd0, 3'd7, 32'h0000_0063);

    // Shrink to 1 x 1: a load at (1,1) must be dropped, not stored.
    drain_and_settle();
    set_dims(4'd1, 4'd1);
    send_item(OP_LOAD_A, 3'd1, 3'd1, 32'h0000_0005);
    send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h0000_0003);
    send_item(OP_MUL, 3'd0, 3'd0, 32'h0000_0000);

    // 2 x 1 refuses the product; add still works on the stored elements.
    drain_and_settle();
    set_dims(4'd2, 4'd1);
    send_item(OP_MUL, 3'd0, 3'd0, 32'h0000_0000);
    send_item(OP_ADD, 3'd0, 3'd0, 32'h0000_0000);

    // Back to 2 x 2: elements kept their positions across the size changes.
    drain_and_settle();
    set_dims(4'd2, 4'd2);
    send_item(OP_ADD, 3'd0, 3'd0, 32'h0000_0000);

    // Register extremes, then mostly small random sizes.
    run_size(4'd1, 4'd8, 12);
    run_size(4'd8, 4'd1, 12);
    run_size(4'd0, 4'd0, 10);
    run_size(4'd15, 4'd15, 6);
    while (work_items < ITEM_TARGET - TAIL_ITEMS) begin
      raw_r = CFG_W'($urandom_range(1, 4));
      raw_c = ($urandom_range(0, 1) == 0) ? raw_r : CFG_W'($urandom_range(1, 4));
      case ($urandom_range(0, 9))
        0: raw_r = '0;
        1: raw_c = '0;
        2: raw_c = 4'd15;
        default: begin
        end
      endcase
      run_size(raw_r, raw_c, $urandom_range(8, 20));
    end

    // Final stretch with both sides running at full rate.
    drain_and_settle();
    quiet_tail <= 1'b1;
    run_size(4'd3, 4'd3, TAIL_ITEMS);
    drain_and_settle();

    $display("Covered %0d input transactions (%0d operations) over %0d size settings,",
             work_items, ops_sent, sizes_run);
    $display("with %0d result elements compared against the prediction.", results_checked);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
